### sv/mrs_pkg.sv
// Shared types, codes and functions of the Modbus RTU slave engine.
`timescale 1ns / 1ps
package mrs_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_GAP   = 2'd1;
  localparam logic [1:0] CMD_READY = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Verdict codes.
  localparam logic [2:0] V_OK       = 3'd0;
  localparam logic [2:0] V_CRC      = 3'd1;
  localparam logic [2:0] V_NOT_ADDR = 3'd2;
  localparam logic [2:0] V_BAD_REQ  = 3'd3;
  localparam logic [2:0] V_OVERFLOW = 3'd4;

  // Result kinds.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Function codes.
  localparam logic [7:0] FN_READ   = 8'h03;
  localparam logic [7:0] FN_WRITE1 = 8'h06;
  localparam logic [7:0] FN_WRITEN = 8'd16;

  localparam int MAX_READ    = 125;
  localparam int MAX_WRITE   = 123;
  localparam int REPLY_BYTES = 256;
  localparam int FCW         = 9;   // frame and reply counters
  localparam int QDEPTH      = 4;
  localparam int QAW         = 2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic           clearing;
    logic           reply_pending;
    logic [FCW-1:0] frame_count;
    logic [FCW-1:0] reply_len;
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CRC_RD, S_CRC_DAT, S_CHECK, S_RHDR, S_HREAD,
    S_HDATA_HI, S_HDATA_LO, S_WR_RD, S_WR_HI, S_WR_LO, S_CRC_LO, S_CRC_HI,
    S_VERDICT, S_TX_OUT
  } state_t;

  // One byte of the reflected CRC-16 (polynomial 0xA001).
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### sv/mrs_front.sv
// Front end: takes input transfers and sorts out the ones worth queuing.
`timescale 1ns / 1ps
module mrs_front (
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [1:0]    s_tuser,   // cmd
  input  logic [7:0]    s_tdata,   // rx_byte
  input  logic          accept_en,
  input  logic          q_full,
  output logic          push,
  output mrs_pkg::item_t push_item
);

  assign s_tready = accept_en && !q_full;

  // Unused command codes are taken and dropped here.
  assign push           = s_tvalid && s_tready && (s_tuser != mrs_pkg::CMD_NONE);
  assign push_item.cmd  = s_tuser;
  assign push_item.data = s_tdata;

endmodule

### sv/mrs_queue.sv
// Short queue of classified items between the front end and the engine.
`timescale 1ns / 1ps
module mrs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrs_pkg::item_t push_item,
  output logic           full,
  output logic           q_valid,
  output mrs_pkg::item_t q_item,
  input  logic           pop
);

  mrs_pkg::item_t            slots [mrs_pkg::QDEPTH];
  logic [mrs_pkg::QAW-1:0]   wr_ptr;
  logic [mrs_pkg::QAW-1:0]   rd_ptr;
  logic [mrs_pkg::QAW:0]     fill;

  assign full    = (fill == (mrs_pkg::QAW+1)'(mrs_pkg::QDEPTH));
  assign q_valid = (fill != '0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### sv/mrs_engine.sv
// Back end: frame store, CRC check, register store, reply build and output register.
`timescale 1ns / 1ps
module mrs_engine #(
  parameter int REG_WORDS   = 4096,
  parameter int FRAME_BYTES = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      slave_address,
  input  logic            q_valid,
  input  mrs_pkg::item_t  q_item,
  output logic            pop,
  output logic            o_valid,
  input  logic            o_ready,
  output logic            o_kind,
  output logic [7:0]      o_byte,
  output logic            o_last,
  output logic [2:0]      o_verdict,
  output mrs_pkg::status_t stat
);

  localparam int HAW = $clog2(REG_WORDS);
  localparam int FAW = $clog2(FRAME_BYTES);
  localparam int FCW = mrs_pkg::FCW;
  localparam logic [HAW-1:0] HLAST = HAW'(REG_WORDS - 1);

  // Memories.
  logic [7:0]  fmem [FRAME_BYTES];
  logic [15:0] hmem [REG_WORDS];
  logic [7:0]  rmem [mrs_pkg::REPLY_BYTES];

  logic           f_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [7:0]     f_wdata, f_rdata;
  logic           h_we;
  logic [HAW-1:0] h_waddr;
  logic [15:0]    h_wdata, h_rdata;
  logic           r_we;
  logic [7:0]     r_wdata, r_rdata;

  // Registers.
  mrs_pkg::state_t state, state_next;
  logic [FCW-1:0] fcount, fcount_next;
  logic           fovf, fovf_next;
  logic           rpend, rpend_next;
  logic [FCW-1:0] rlen, rlen_next;
  logic [FCW-1:0] rpos, rpos_next;
  logic [7:0]     wptr, wptr_next;
  logic [FCW-1:0] j, j_next;
  logic [6:0]     cnt, cnt_next;
  logic [15:0]    fcrc, fcrc_next;
  logic [15:0]    rcrc, rcrc_next;
  logic [7:0]     rx_lo, rx_lo_next, rx_hi, rx_hi_next;
  logic [7:0]     hdr [7];
  logic [7:0]     hdr_next [7];
  logic [2:0]     vd, vd_next;
  logic [HAW-1:0] clr_idx, clr_idx_next;
  logic [7:0]     hold, hold_next;
  logic           o_valid_next, o_kind_next, o_last_next;
  logic [7:0]     o_byte_next;
  logic [2:0]     o_verdict_next;

  // Request decode.
  logic [7:0]     fn;
  logic [15:0]    addr, qty;
  logic [16:0]    end17, qty2;
  logic           out_free, crc_ok, addr_ok, fn_ok, rd_bad, w6_bad, w16_bad;
  logic [2:0]     check_v;
  logic [HAW-1:0] haddr;
  logic [FCW-1:0] fw_addr;
  logic           crc_empty, tx_none, tx_last;
  logic [7:0]     hdr_len;
  logic           hdr_end, loop_end;

  assign fn       = hdr[1];
  assign addr     = {hdr[2], hdr[3]};
  assign qty      = {hdr[4], hdr[5]};
  assign end17    = {1'b0, addr} + {1'b0, qty};
  assign qty2     = {qty, 1'b0};
  assign out_free = !o_valid || o_ready;
  assign crc_ok   = (fcrc == {rx_hi, rx_lo});
  assign addr_ok  = (hdr[0] != 8'h00) && (hdr[0] == slave_address);
  assign fn_ok    = (fn == mrs_pkg::FN_READ) || (fn == mrs_pkg::FN_WRITE1)
                 || (fn == mrs_pkg::FN_WRITEN);
  assign rd_bad   = (fcount != FCW'(8)) || (qty == 16'd0)
                 || (qty > 16'(mrs_pkg::MAX_READ)) || (end17 > 17'(REG_WORDS));
  assign w6_bad   = (fcount != FCW'(8)) || ({1'b0, addr} >= 17'(REG_WORDS));
  assign w16_bad  = (qty == 16'd0) || (qty > 16'(mrs_pkg::MAX_WRITE))
                 || (17'(fcount) != 17'd9 + qty2) || ({9'd0, hdr[6]} != qty2)
                 || (end17 > 17'(REG_WORDS));
  assign haddr    = addr[HAW-1:0] + HAW'(cnt);
  assign fw_addr  = {1'b0, cnt, 1'b0} + FCW'(7);
  assign crc_empty = (fcount == '0) && !fovf;
  assign tx_none  = !rpend || (rpos >= rlen);
  assign tx_last  = (rpos + 1'b1 >= rlen);
  assign hdr_len  = (fn == mrs_pkg::FN_READ) ? 8'd3 : 8'd6;
  assign hdr_end  = (wptr == hdr_len - 8'd1);
  assign loop_end = (cnt == qty[6:0] - 7'd1);

  always_comb begin
    priority if (!crc_ok)                               check_v = mrs_pkg::V_CRC;
    else if (!addr_ok)                                  check_v = mrs_pkg::V_NOT_ADDR;
    else if (!fn_ok)                                    check_v = mrs_pkg::V_BAD_REQ;
    else if (fcount < FCW'(8))                          check_v = mrs_pkg::V_BAD_REQ;
    else if ((fn == mrs_pkg::FN_READ) && rd_bad)        check_v = mrs_pkg::V_BAD_REQ;
    else if ((fn == mrs_pkg::FN_WRITE1) && w6_bad)      check_v = mrs_pkg::V_BAD_REQ;
    else if ((fn == mrs_pkg::FN_WRITEN) && w16_bad)     check_v = mrs_pkg::V_BAD_REQ;
    else                                                check_v = mrs_pkg::V_OK;
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    f_rdata <= fmem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[h_waddr] <= h_wdata;
    h_rdata <= hmem[haddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) rmem[wptr] <= r_wdata;
    r_rdata <= rmem[rpos[7:0]];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mrs_pkg::S_CLEAR:    if (clr_idx == HLAST) state_next = mrs_pkg::S_IDLE;
      mrs_pkg::S_IDLE: begin
        if (q_valid) begin
          if (q_item.cmd == mrs_pkg::CMD_GAP && !crc_empty) begin
            if (fovf || fcount < FCW'(4)) state_next = mrs_pkg::S_VERDICT;
            else                          state_next = mrs_pkg::S_CRC_RD;
          end else if (q_item.cmd == mrs_pkg::CMD_READY && !tx_none) begin
            state_next = mrs_pkg::S_TX_OUT;
          end
        end
      end
      mrs_pkg::S_CRC_RD:   state_next = mrs_pkg::S_CRC_DAT;
      mrs_pkg::S_CRC_DAT:  state_next = (j == fcount - 1'b1) ? mrs_pkg::S_CHECK
                                                              : mrs_pkg::S_CRC_RD;
      mrs_pkg::S_CHECK: begin
        if (check_v != mrs_pkg::V_OK)          state_next = mrs_pkg::S_VERDICT;
        else if (fn == mrs_pkg::FN_WRITEN)     state_next = mrs_pkg::S_WR_RD;
        else                                   state_next = mrs_pkg::S_RHDR;
      end
      mrs_pkg::S_RHDR: begin
        if (hdr_end) begin
          state_next = (fn == mrs_pkg::FN_READ) ? mrs_pkg::S_HREAD : mrs_pkg::S_CRC_LO;
        end
      end
      mrs_pkg::S_HREAD:    state_next = mrs_pkg::S_HDATA_HI;
      mrs_pkg::S_HDATA_HI: state_next = mrs_pkg::S_HDATA_LO;
      mrs_pkg::S_HDATA_LO: state_next = loop_end ? mrs_pkg::S_CRC_LO : mrs_pkg::S_HREAD;
      mrs_pkg::S_WR_RD:    state_next = mrs_pkg::S_WR_HI;
      mrs_pkg::S_WR_HI:    state_next = mrs_pkg::S_WR_LO;
      mrs_pkg::S_WR_LO:    state_next = loop_end ? mrs_pkg::S_RHDR : mrs_pkg::S_WR_RD;
      mrs_pkg::S_CRC_LO:   state_next = mrs_pkg::S_CRC_HI;
      mrs_pkg::S_CRC_HI:   state_next = mrs_pkg::S_VERDICT;
      mrs_pkg::S_VERDICT:  if (out_free) state_next = mrs_pkg::S_IDLE;
      mrs_pkg::S_TX_OUT:   if (out_free) state_next = mrs_pkg::S_IDLE;
      default:             state_next = mrs_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    fcount_next    = fcount;
    fovf_next      = fovf;
    rpend_next     = rpend;
    rlen_next      = rlen;
    rpos_next      = rpos;
    wptr_next      = wptr;
    j_next         = j;
    cnt_next       = cnt;
    fcrc_next      = fcrc;
    rcrc_next      = rcrc;
    rx_lo_next     = rx_lo;
    rx_hi_next     = rx_hi;
    hdr_next       = hdr;
    vd_next        = vd;
    clr_idx_next   = clr_idx;
    hold_next      = hold;
    o_valid_next   = o_valid && !o_ready;
    o_kind_next    = o_kind;
    o_byte_next    = o_byte;
    o_last_next    = o_last;
    o_verdict_next = o_verdict;
    pop     = 1'b0;
    f_we    = 1'b0;
    f_waddr = fcount[FAW-1:0];
    f_wdata = q_item.data;
    f_raddr = j[FAW-1:0];
    h_we    = 1'b0;
    h_waddr = haddr;
    h_wdata = {hold, f_rdata};
    r_we    = 1'b0;
    r_wdata = hdr[wptr[2:0]];

    unique case (state)
      mrs_pkg::S_CLEAR: begin
        h_we         = 1'b1;
        h_waddr      = clr_idx;
        h_wdata      = 16'h0000;
        clr_idx_next = clr_idx + 1'b1;
      end
      mrs_pkg::S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          unique case (q_item.cmd)
            mrs_pkg::CMD_BYTE: begin
              if (!rpend) begin
                if (fcount < FCW'(FRAME_BYTES)) begin
                  f_we        = 1'b1;
                  fcount_next = fcount + 1'b1;
                end else begin
                  fovf_next = 1'b1;
                end
              end
            end
            mrs_pkg::CMD_GAP: begin
              if (!crc_empty) begin
                j_next    = '0;
                fcrc_next = 16'hFFFF;
                if (fovf)                    vd_next = mrs_pkg::V_OVERFLOW;
                else if (fcount < FCW'(4))   vd_next = mrs_pkg::V_CRC;
              end
            end
            mrs_pkg::CMD_READY: begin
              if (tx_none) rpend_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      mrs_pkg::S_CRC_RD: ;
      mrs_pkg::S_CRC_DAT: begin
        if (j < fcount - FCW'(2)) fcrc_next = mrs_pkg::crc_byte(fcrc, f_rdata);
        if (j == fcount - FCW'(2)) rx_lo_next = f_rdata;
        if (j == fcount - FCW'(1)) rx_hi_next = f_rdata;
        if (j < FCW'(7)) hdr_next[j[2:0]] = f_rdata;
        j_next = j + 1'b1;
      end
      mrs_pkg::S_CHECK: begin
        vd_next   = check_v;
        rcrc_next = 16'hFFFF;
        wptr_next = '0;
        cnt_next  = '0;
        if (check_v == mrs_pkg::V_OK && fn == mrs_pkg::FN_WRITE1) begin
          h_we    = 1'b1;
          h_waddr = addr[HAW-1:0];
          h_wdata = qty;
        end
      end
      mrs_pkg::S_RHDR: begin
        r_we = 1'b1;
        if (fn == mrs_pkg::FN_READ && wptr == 8'd2) r_wdata = {qty[6:0], 1'b0};
        rcrc_next = mrs_pkg::crc_byte(rcrc, r_wdata);
        wptr_next = wptr + 1'b1;
      end
      mrs_pkg::S_HREAD: ;
      mrs_pkg::S_HDATA_HI: begin
        r_we      = 1'b1;
        r_wdata   = h_rdata[15:8];
        hold_next = h_rdata[7:0];
        rcrc_next = mrs_pkg::crc_byte(rcrc, r_wdata);
        wptr_next = wptr + 1'b1;
      end
      mrs_pkg::S_HDATA_LO: begin
        r_we      = 1'b1;
        r_wdata   = hold;
        rcrc_next = mrs_pkg::crc_byte(rcrc, r_wdata);
        wptr_next = wptr + 1'b1;
        cnt_next  = cnt + 1'b1;
      end
      mrs_pkg::S_WR_RD: begin
        f_raddr = fw_addr[FAW-1:0];
      end
      mrs_pkg::S_WR_HI: begin
        f_raddr   = fw_addr[FAW-1:0] + 1'b1;
        hold_next = f_rdata;
      end
      mrs_pkg::S_WR_LO: begin
        h_we     = 1'b1;
        cnt_next = cnt + 1'b1;
      end
      mrs_pkg::S_CRC_LO: begin
        r_we      = 1'b1;
        r_wdata   = rcrc[7:0];
        wptr_next = wptr + 1'b1;
      end
      mrs_pkg::S_CRC_HI: begin
        r_we       = 1'b1;
        r_wdata    = rcrc[15:8];
        rlen_next  = {1'b0, wptr} + 1'b1;
        rpos_next  = '0;
        rpend_next = 1'b1;
      end
      mrs_pkg::S_VERDICT: begin
        if (out_free) begin
          o_valid_next   = 1'b1;
          o_kind_next    = mrs_pkg::KIND_VERDICT;
          o_byte_next    = 8'h00;
          o_last_next    = 1'b0;
          o_verdict_next = vd;
          fcount_next    = '0;
          fovf_next      = 1'b0;
        end
      end
      mrs_pkg::S_TX_OUT: begin
        if (out_free) begin
          o_valid_next   = 1'b1;
          o_kind_next    = mrs_pkg::KIND_BYTE;
          o_byte_next    = r_rdata;
          o_last_next    = tx_last;
          o_verdict_next = mrs_pkg::V_OK;
          rpos_next      = rpos + 1'b1;
          if (tx_last) begin
            rpend_next = 1'b0;
            rpos_next  = '0;
            rlen_next  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mrs_pkg::S_CLEAR;
      fcount  <= '0;
      fovf    <= 1'b0;
      rpend   <= 1'b0;
      rlen    <= '0;
      rpos    <= '0;
      clr_idx <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      fcount  <= fcount_next;
      fovf    <= fovf_next;
      rpend   <= rpend_next;
      rlen    <= rlen_next;
      rpos    <= rpos_next;
      clr_idx <= clr_idx_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    wptr      <= wptr_next;
    j         <= j_next;
    cnt       <= cnt_next;
    fcrc      <= fcrc_next;
    rcrc      <= rcrc_next;
    rx_lo     <= rx_lo_next;
    rx_hi     <= rx_hi_next;
    hdr       <= hdr_next;
    vd        <= vd_next;
    hold      <= hold_next;
    o_kind    <= o_kind_next;
    o_byte    <= o_byte_next;
    o_last    <= o_last_next;
    o_verdict <= o_verdict_next;
  end

  assign stat.clearing      = (state == mrs_pkg::S_CLEAR);
  assign stat.reply_pending = rpend;
  assign stat.frame_count   = fcount;
  assign stat.reply_len     = rlen;

endmodule

### sv/modbus_rtu_slave_engine.sv
// Top level of the Modbus RTU slave engine: configuration, front end, queue and engine.
`timescale 1ns / 1ps
// The slave channel (s_*) takes one command per transfer: tuser carries the
// command (received byte, end-of-frame gap, transmitter-ready slot) and
// tdata the received byte. The master channel (m_*) gives one result per
// transfer: tuser is the kind (reply byte or frame verdict), tdata holds the
// reply byte in bits 7:0 and the verdict in bits 10:8, and tlast marks the
// final reply byte. The cfg channel writes the own station address and is
// always ready; the user must write it only while the block is idle, and the
// block itself does not enforce this. Accepted commands other than the unused
// code go into a four-entry queue, so the front keeps taking transfers while
// the engine works or a result waits on a stalled receiver. The engine takes
// a received byte in its idle state; a ready slot passes to the transmit
// state, which registers the reply byte onto the master channel. A gap runs a
// CRC pass over the frame store, one byte at a time through its single read
// port, then the register reads or writes and the reply build.
// After reset the register store is cleared one word a cycle, and s_tready
// stays low until that pass ends.
// When the receiver stalls the result waits in the output register; the
// engine then stalls and the queue fills before s_tready falls.
module modbus_rtu_slave_engine #(
  parameter int REG_WORDS   = 4096,
  parameter int FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,    // slave_address
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,     // cmd
  input  logic [7:0]  s_tdata,     // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic        m_tuser,     // kind
  output logic [15:0] m_tdata,     // tx_byte [7:0], verdict [10:8], zero fill
  output logic        m_tlast      // tx_last
);

  logic [7:0]       slave_address;
  logic             push, q_full, q_valid, pop;
  mrs_pkg::item_t   push_item, q_item;
  mrs_pkg::status_t stat;
  logic [7:0]       tx_byte;
  logic [2:0]       verdict;

  // The address register takes a write on every cfg transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      slave_address <= cfg_data;
    end
  end

  mrs_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .accept_en (!stat.clearing),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  mrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  mrs_engine #(
    .REG_WORDS   (REG_WORDS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .o_valid       (m_tvalid),
    .o_ready       (m_tready),
    .o_kind        (m_tuser),
    .o_byte        (tx_byte),
    .o_last        (m_tlast),
    .o_verdict     (verdict),
    .stat          (stat)
  );

  assign m_tdata = {5'b00000, verdict, tx_byte};

`ifndef SYNTHESIS
  // No command is taken while the register store is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !s_tready)
    else $error("input accepted during clearing pass");

  // The frame counter never passes the frame store size.
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    stat.frame_count <= 9'(FRAME_BYTES))
    else $error("frame count beyond store");

  // A pending reply holds at least a one-register read reply and at most a full read reply.
  a_reply_len: assert property (@(posedge clk) disable iff (rst)
    stat.reply_pending |-> (stat.reply_len >= 9'd7 && stat.reply_len <= 9'd255))
    else $error("pending reply length out of range");

  // A verdict result carries no reply byte and no last mark.
  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[7:0] == 8'h00 && !m_tlast))
    else $error("verdict result with byte fields set");
`endif

endmodule

### test/tb_modbus_rtu_slave_engine.sv
// Self-checking testbench of the Modbus RTU slave engine, driven through its stream ports.
`timescale 1ns / 1ps
module tb_modbus_rtu_slave_engine;

  localparam int REGS = 4096;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [2:0] verdict;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = mrs_pkg::CMD_NONE;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        m_tuser;
  logic [15:0] m_tdata;
  logic        m_tlast;

  modbus_rtu_slave_engine uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Shadow state of the slave.
  logic [7:0]  own_addr;
  logic [7:0]  rx_frame [0:255];
  int          rx_count;
  bit          rx_over;
  logic [15:0] regs_shadow [0:REGS-1];
  logic [7:0]  tx_frame [0:255];
  int          tx_len;
  int          tx_pos;
  bit          tx_busy;

  mrs_pkg::item_t cmd_queue [$];
  outcome_t expected_results [$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int verdicts_seen = 0;
  bit hold_rx = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  function automatic logic [15:0] crc_of(input logic [7:0] b [0:255], input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, b[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void seal_reply(input int n);
    logic [15:0] c;
    c = crc_of(tx_frame, n);
    tx_frame[n] = c[7:0];
    tx_frame[n+1] = c[15:8];
    tx_len = n + 2;
    tx_pos = 0;
    tx_busy = 1'b1;
  endfunction

  // Checks a finished frame in the same order as the slave, acting on the registers.
  function automatic logic [2:0] judge_request();
    int n, fn, addr, qty;
    n = rx_count;
    if (rx_over) return mrs_pkg::V_OVERFLOW;
    if (n < 4) return mrs_pkg::V_CRC;
    if (crc_of(rx_frame, n - 2) != {rx_frame[n-1], rx_frame[n-2]}) return mrs_pkg::V_CRC;
    if (rx_frame[0] == 8'd0 || rx_frame[0] != own_addr) return mrs_pkg::V_NOT_ADDR;
    fn = rx_frame[1];
    if (fn != mrs_pkg::FN_READ && fn != mrs_pkg::FN_WRITE1 && fn != mrs_pkg::FN_WRITEN)
      return mrs_pkg::V_BAD_REQ;
    if (n < 8) return mrs_pkg::V_BAD_REQ;
    addr = {rx_frame[2], rx_frame[3]};
    qty = {rx_frame[4], rx_frame[5]};
    if (fn == mrs_pkg::FN_READ) begin
      if (n != 8 || qty < 1 || qty > mrs_pkg::MAX_READ || addr + qty > REGS)
        return mrs_pkg::V_BAD_REQ;
      tx_frame[0] = own_addr;
      tx_frame[1] = mrs_pkg::FN_READ;
      tx_frame[2] = 8'(qty * 2);
      for (int i = 0; i < qty; i++) begin
        tx_frame[3+2*i] = regs_shadow[addr+i][15:8];
        tx_frame[4+2*i] = regs_shadow[addr+i][7:0];
      end
      seal_reply(3 + 2 * qty);
      return mrs_pkg::V_OK;
    end
    if (fn == mrs_pkg::FN_WRITE1) begin
      if (n != 8 || addr >= REGS) return mrs_pkg::V_BAD_REQ;
      regs_shadow[addr] = 16'(qty);
    end else begin
      if (qty < 1 || qty > mrs_pkg::MAX_WRITE || n != 9 + 2 * qty ||
          rx_frame[6] != 8'(qty * 2) || addr + qty > REGS) return mrs_pkg::V_BAD_REQ;
      for (int i = 0; i < qty; i++) regs_shadow[addr+i] = {rx_frame[7+2*i], rx_frame[8+2*i]};
    end
    for (int i = 0; i < 6; i++) tx_frame[i] = rx_frame[i];
    seal_reply(6);
    return mrs_pkg::V_OK;
  endfunction

  // Applies one accepted command to the shadow and queues what it should produce.
  task automatic predict_command(input mrs_pkg::item_t it);
    outcome_t o;
    o = '0;
    case (it.cmd)
      mrs_pkg::CMD_BYTE: begin
        if (!tx_busy) begin
          if (rx_count < 256) begin
            rx_frame[rx_count] = it.data;
            rx_count++;
          end else begin
            rx_over = 1'b1;
          end
        end
      end
      mrs_pkg::CMD_GAP: begin
        if (rx_count != 0 || rx_over) begin
          o.kind = mrs_pkg::KIND_VERDICT;
          o.verdict = judge_request();
          rx_count = 0;
          rx_over = 1'b0;
          expected_results.push_back(o);
        end
      end
      mrs_pkg::CMD_READY: begin
        if (!tx_busy || tx_pos >= tx_len) begin
          tx_busy = 1'b0;
        end else begin
          o.kind = mrs_pkg::KIND_BYTE;
          o.tx_byte = tx_frame[tx_pos];
          o.tx_last = (tx_pos + 1 >= tx_len);
          tx_pos++;
          if (o.tx_last) begin
            tx_busy = 1'b0;
            tx_pos = 0;
            tx_len = 0;
          end
          expected_results.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Driver: offers queued commands with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_command('{cmd: s_tuser, data: s_tdata});
        sent++;
        void'(cmd_queue.pop_front());
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                               : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
      end
      if (s_tvalid && !s_tready) begin
        // Keep offering the same item.
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (cmd_queue.size() > (s_tvalid && s_tready ? 0 : 0)) begin
        s_tvalid <= 1'b1;
        s_tuser <= cmd_queue[0].cmd;
        s_tdata <= cmd_queue[0].data;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: accepts results with random stalls and compares them in order.
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{kind: m_tuser, tx_byte: m_tdata[7:0], tx_last: m_tlast,
                verdict: m_tdata[10:8]};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.kind == mrs_pkg::KIND_VERDICT) verdicts_seen++;
          if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d exp %0d", got.kind, want.kind));
          if (got.tx_byte != want.tx_byte)
            report_mismatch($sformatf("tx_byte %h exp %h", got.tx_byte, want.tx_byte));
          if (got.tx_last != want.tx_last)
            report_mismatch($sformatf("tx_last %0d exp %0d", got.tx_last, want.tx_last));
          if (got.verdict != want.verdict)
            report_mismatch($sformatf("verdict %0d exp %0d", got.verdict, want.verdict));
          if (m_tdata[15:11] != 5'd0) report_mismatch("nonzero fill bits in m_tdata");
        end
      end
      if (hold_rx) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                 : $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Frame builders.
  task automatic push_cmd(input logic [1:0] c, input logic [7:0] d);
    cmd_queue.push_back('{cmd: c, data: d});
  endtask

  task automatic push_frame(input logic [7:0] b [0:255], input int n, input bit good_crc);
    logic [15:0] c;
    c = crc_of(b, n);
    if (!good_crc) c = c ^ 16'(1 << $urandom_range(0, 15));
    for (int i = 0; i < n; i++) push_cmd(mrs_pkg::CMD_BYTE, b[i]);
    push_cmd(mrs_pkg::CMD_BYTE, c[7:0]);
    push_cmd(mrs_pkg::CMD_BYTE, c[15:8]);
    push_cmd(mrs_pkg::CMD_GAP, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_drain(input int n);
    for (int i = 0; i < n; i++) push_cmd(mrs_pkg::CMD_READY, 8'($urandom_range(0, 255)));
  endtask

  // Builds a request; fn selects read, single write, multi write.
  task automatic push_request(input logic [7:0] addr, input logic [7:0] fn, input int start,
                              input int qty, input bit good_crc);
    logic [7:0] b [0:255];
    int n, cap;
    b[0] = addr;
    b[1] = fn;
    b[2] = 8'(start >> 8);
    b[3] = 8'(start);
    b[4] = 8'(qty >> 8);
    b[5] = 8'(qty);
    n = 6;
    // A quantity past the write limit is refused anyway, so four data bytes do.
    cap = (qty > mrs_pkg::MAX_WRITE) ? 4 : 240;
    if (fn == mrs_pkg::FN_WRITEN) begin
      b[6] = 8'(qty * 2);
      for (int i = 0; i < 2 * qty && i < cap; i++) b[7+i] = 8'($urandom_range(0, 255));
      n = 7 + ((2 * qty < cap) ? 2 * qty : cap);
    end
    push_frame(b, n, good_crc);
    push_drain((fn == mrs_pkg::FN_READ && qty <= mrs_pkg::MAX_READ) ? 2 * qty + 6 : 9);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
           && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    // A frame may still be judged without result after the last expectation.
    repeat (600) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    own_addr = a;
  endtask

  task automatic random_phase(input int items);
    int start, qty, pick;
    logic [7:0] fn, a;
    logic [7:0] b [0:255];
    while (items > 0) begin
      pick = $urandom_range(0, 19);
      a = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : own_addr;
      start = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, REGS - 1);
      if (pick < 6) begin
        fn = mrs_pkg::FN_READ;
        qty = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 130) : $urandom_range(1, 8);
        if (start + qty > REGS && $urandom_range(0, 1)) start = REGS - qty;
        push_request(a, fn, start, qty, $urandom_range(0, 9) != 0);
        items -= 10 + 2 * qty;
      end else if (pick < 11) begin
        push_request(a, mrs_pkg::FN_WRITE1, start, $urandom_range(0, 65535),
                     $urandom_range(0, 9) != 0);
        items -= 18;
      end else if (pick < 16) begin
        qty = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(1, 6);
        if (start + qty > REGS && $urandom_range(0, 1)) start = REGS - qty;
        push_request(a, mrs_pkg::FN_WRITEN, start, qty, $urandom_range(0, 9) != 0);
        items -= 19 + 2 * qty;
      end else begin
        // Noise: random bytes, stray commands, odd function codes.
        qty = $urandom_range(0, 10);
        for (int i = 0; i < qty; i++) b[i] = 8'($urandom_range(0, 255));
        b[0] = a;
        if (qty > 0 && $urandom_range(0, 1)) push_frame(b, qty, 1'b1);
        else begin
          for (int i = 0; i < qty; i++) push_cmd(2'($urandom_range(0, 3)), b[i]);
          push_cmd(mrs_pkg::CMD_GAP, 8'h00);
        end
        push_drain(3);
        items -= qty + 4;
      end
    end
  endtask

  initial begin
    logic [7:0] b [0:255];
    own_addr = 8'd1;
    rx_count = 0;
    rx_over = 1'b0;
    tx_len = 0;
    tx_pos = 0;
    tx_busy = 1'b0;
    for (int i = 0; i < REGS; i++) regs_shadow[i] = 16'h0000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: every function, the ranges, and each corner the slave handles.
    push_cmd(mrs_pkg::CMD_READY, 8'hFF);     // ready with nothing pending
    push_cmd(mrs_pkg::CMD_GAP, 8'h00);       // empty gap
    push_cmd(mrs_pkg::CMD_NONE, 8'hAA);      // unused command
    push_cmd(mrs_pkg::CMD_BYTE, 8'h01);
    push_cmd(mrs_pkg::CMD_BYTE, 8'h03);
    push_cmd(mrs_pkg::CMD_GAP, 8'h55);       // short frame
    push_request(8'd1, mrs_pkg::FN_WRITE1, REGS - 1, 16'hFFFF, 1'b1);
    push_request(8'd1, mrs_pkg::FN_READ, REGS - 1, 1, 1'b1);
    push_cmd(mrs_pkg::CMD_BYTE, 8'h11);      // joins the next frame: no reply pending
    push_drain(2);
    push_request(8'd1, mrs_pkg::FN_WRITEN, 0, 3, 1'b1);
    push_request(8'd1, mrs_pkg::FN_READ, 0, mrs_pkg::MAX_READ, 1'b1);
    push_request(8'd1, mrs_pkg::FN_READ, 0, mrs_pkg::MAX_READ + 1, 1'b1);
    push_request(8'd1, mrs_pkg::FN_WRITEN, REGS - mrs_pkg::MAX_WRITE, mrs_pkg::MAX_WRITE,
                 1'b1);
    push_request(8'd1, mrs_pkg::FN_WRITEN, 0, mrs_pkg::MAX_WRITE + 1, 1'b1);
    push_request(8'd1, mrs_pkg::FN_WRITE1, REGS, 1, 1'b1);
    push_request(8'd1, mrs_pkg::FN_READ, REGS - 2, 3, 1'b1);
    push_request(8'd0, mrs_pkg::FN_READ, 0, 1, 1'b1);  // broadcast
    push_request(8'd9, mrs_pkg::FN_READ, 0, 1, 1'b1);
    push_request(8'd1, mrs_pkg::FN_READ, 0, 1, 1'b0);  // CRC bad
    push_request(8'd1, 8'h04, 0, 1, 1'b1);             // unsupported function
    for (int i = 0; i < 260; i++) push_cmd(mrs_pkg::CMD_BYTE, 8'(i));
    push_cmd(mrs_pkg::CMD_GAP, 8'h00);                  // overflow
    b[0] = 8'd1; b[1] = mrs_pkg::FN_READ; b[2] = 8'd0; b[3] = 8'd0;
    push_frame(b, 4, 1'b1);                             // read shorter than 8 bytes
    wait_idle();

    // Long receiver hold-off so the input side backs up.
    hold_rx = 1'b1;
    random_phase(120);
    repeat (3000) @(posedge clk);
    hold_rx = 1'b0;
    wait_idle();

    write_address(8'd247);
    random_phase(60);
    wait_idle();
    write_address(8'd1);
    random_phase(60);
    wait_idle();
    write_address(8'($urandom_range(2, 246)));
    random_phase(60);
    wait_idle();

    $display("Covered %0d commands, %0d results checked, %0d frame verdicts,",
             sent, checked, verdicts_seen);
    $display("three station addresses including both ends of the range.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (expected_results.size() != 0)
        $display("%0d expected results never arrived", expected_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
